// ===== hdl/alst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alst_pkg
// Shared sizes, types and helpers for the array list engine.
// ----------------------------------------------------------------------------
package alst_pkg;

   localparam int CAPACITY   = 256;
   localparam int DATA_WIDTH = 32;
   localparam int IN_W       = 32;
   localparam int POS_W      = 8;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int GROUP      = 16;
   localparam int NGROUP     = (CAPACITY + GROUP - 1) / GROUP;

   typedef logic [DATA_WIDTH-1:0] word_type;

   typedef enum logic [2:0] {
      FN_READ_AT       = 3'd0,
      FN_INSERT_AT     = 3'd1,
      FN_INSERT_SORTED = 3'd2,
      FN_REMOVE_AT     = 3'd3,
      FN_REMOVE_KEY    = 3'd4,
      FN_CLEAR         = 3'd5,
      FN_INSERT_TAIL   = 3'd6,
      FN_REMOVE_TAIL   = 3'd7
   } func_type;

   // per-cell move controls for one row update
   typedef struct packed {
      logic up;    // take lower neighbor
      logic down;  // take upper neighbor
      logic put;   // take the request word
   } cell_ctl_type;

   // input word to stored width, sign kept
   function automatic word_type to_word(input logic [IN_W-1:0] v);
      word_type r;
      for (int i = 0; i < DATA_WIDTH; i++) begin
         r[i] = (i < IN_W) ? v[i] : v[IN_W-1];
      end
      return r;
   endfunction

   // stored word to output width, sign kept
   function automatic logic [IN_W-1:0] from_word(input word_type d);
      logic [IN_W-1:0] r;
      for (int i = 0; i < IN_W; i++) begin
         r[i] = (i < DATA_WIDTH) ? d[i] : d[DATA_WIDTH-1];
      end
      return r;
   endfunction

endpackage

// ===== hdl/alst_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alst_cell
// One list slot: holds a word, compares it against the request word and
// moves data to or from its neighbors.
// ----------------------------------------------------------------------------
module alst_cell
   import alst_pkg::*;
(
   input  logic         clock,
   input  word_type     key,
   input  word_type     lower_word,
   input  word_type     upper_word,
   input  cell_ctl_type ctl,
   output word_type     word,
   output logic         greater,
   output logic         equal
);

   word_type word_ff, word_in;
   logic     greater_ff, equal_ff;

   always_comb begin
      word_in = word_ff;
      if (ctl.put) begin
         word_in = key;
      end else if (ctl.up) begin
         word_in = lower_word;
      end else if (ctl.down) begin
         word_in = upper_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff    <= word_in;
      greater_ff <= $signed(word_ff) > $signed(key);
      equal_ff   <= word_ff == key;
   end

   assign word    = word_ff;
   assign greater = greater_ff;
   assign equal   = equal_ff;

endmodule

// ===== hdl/alst_pick.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alst_pick
// Two-stage registered OR tree that pulls the one selected word out of
// the cell row.
// ----------------------------------------------------------------------------
module alst_pick
   import alst_pkg::*;
(
   input  logic                clock,
   input  logic [CAPACITY-1:0] sel,
   input  word_type            words [CAPACITY],
   output logic [IN_W-1:0]     value
);

   word_type        grp_ff [NGROUP];
   word_type        grp_in [NGROUP];
   logic [IN_W-1:0] value_ff, value_in;

   always_comb begin
      int idx;
      for (int g = 0; g < NGROUP; g++) begin
         grp_in[g] = '0;
         for (int j = 0; j < GROUP; j++) begin
            idx = g * GROUP + j;
            if (idx < CAPACITY) begin
               if (sel[idx]) begin
                  grp_in[g] = grp_in[g] | words[idx];
               end
            end
         end
      end
   end

   always_comb begin
      word_type acc;
      acc = '0;
      for (int g = 0; g < NGROUP; g++) begin
         acc = acc | grp_ff[g];
      end
      value_in = from_word(acc);
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NGROUP; g++) begin
         grp_ff[g] <= grp_in[g];
      end
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== hdl/array_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_engine
// Packed list of signed words kept in a row of cells, with a count.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_func, req_position and req_value_in and raise start;
//   the word is taken on a clock edge where start is high and busy is low.
//   busy stays high while the operation runs.
//   Response: rsp_valid strobes for one cycle with ok, value, count, free
//   slots and empty/full flags. The receiver cannot stall; it must take the
//   word in that cycle.
//   Timing: each operation runs through capture, compare in every cell,
//   build the move masks (prefix/suffix OR across the row), shift the row
//   while the first read-out OR stage samples the old row, then the second
//   OR stage along with the response registers, which raise rsp_valid. A
//   new request can be taken on the edge at which the response is taken.
//   Every cell moves at once, so list length does not change the latency.
//   Reset: synchronous, clears the count and control; cell contents are
//   left as they are and are never read before being written.
// ----------------------------------------------------------------------------
module array_list_engine
   import alst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [2:0]            req_func,
   input  logic [POS_W-1:0]      req_position,
   input  logic signed [IN_W-1:0] req_value_in,
   output logic                  rsp_valid,
   output logic                  rsp_ok,
   output logic signed [IN_W-1:0] rsp_value_out,
   output logic [CNT_W-1:0]      rsp_count,
   output logic [CNT_W-1:0]      rsp_free_slots,
   output logic                  rsp_is_empty,
   output logic                  rsp_is_full
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP,
      ST_MASK,
      ST_APPLY,
      ST_DRAIN
   } state_type;

   state_type           state_ff;
   func_type            func_ff;
   logic [POS_W-1:0]    pos_ff;
   word_type            key_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_nx_ff, count_nx_in;
   logic                ok_ff, ok_in;
   cell_ctl_type        ctl_ff [CAPACITY];
   cell_ctl_type        ctl_in [CAPACITY];
   logic [CAPACITY-1:0] sel_ff, sel_in;
   logic                rsp_valid_ff, rsp_ok_ff, rsp_empty_ff, rsp_full_ff;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_free_ff;

   word_type            words    [CAPACITY];
   word_type            lower_nb [CAPACITY];
   word_type            upper_nb [CAPACITY];
   logic [CAPACITY-1:0] gt_vec, eq_vec;
   logic [IN_W-1:0]     pick_value;

   // ---- cell row ----
   always_comb begin
      for (int k = 0; k < CAPACITY; k++) begin
         lower_nb[k] = (k == 0) ? '0 : words[(k == 0) ? 0 : k - 1];
         upper_nb[k] = (k == CAPACITY - 1) ? '0
                       : words[(k == CAPACITY - 1) ? k : k + 1];
      end
   end

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      alst_cell u_cell (
         .clock      (clock),
         .key        (key_ff),
         .lower_word (lower_nb[k]),
         .upper_word (upper_nb[k]),
         .ctl        (ctl_ff[k]),
         .word       (words[k]),
         .greater    (gt_vec[k]),
         .equal      (eq_vec[k])
      );
   end

   alst_pick u_pick (
      .clock (clock),
      .sel   (sel_ff),
      .words (words),
      .value (pick_value)
   );

   // ---- move masks ----
   always_comb begin
      logic [CMP_W-1:0]    c, p, kk;
      logic [CAPACITY-1:0] live, hit, pre, bad, suf, suf_lo, pre_lo;
      logic                is_ins, is_rem, room;

      c = CMP_W'(count_ff);
      p = CMP_W'(pos_ff);
      if (func_ff == FN_INSERT_TAIL) begin
         p = c;
      end else if (func_ff == FN_REMOVE_TAIL) begin
         p = c - CMP_W'(1);
      end
      room = count_ff != CNT_W'(CAPACITY);

      for (int k = 0; k < CAPACITY; k++) begin
         kk = CMP_W'(k);
         live[k] = kk < c;
      end

      // first key match: prefix OR
      hit = live & eq_vec;
      pre = hit;
      for (int s = 1; s < CAPACITY; s = s * 2) begin
         pre = pre | (pre << s);
      end
      pre_lo = pre << 1;

      // sorted insert: last element not greater than key, suffix OR
      bad = live & ~gt_vec;
      suf = bad;
      for (int s = 1; s < CAPACITY; s = s * 2) begin
         suf = suf | (suf >> s);
      end
      suf_lo = suf << 1;

      is_ins = 1'b0;
      is_rem = 1'b0;
      ok_in  = 1'b0;
      case (func_ff)
         FN_READ_AT:       ok_in = p < c;
         FN_INSERT_AT,
         FN_INSERT_TAIL:   begin
            ok_in  = room && (p <= c);
            is_ins = 1'b1;
         end
         FN_INSERT_SORTED: begin
            ok_in  = room;
            is_ins = 1'b1;
         end
         FN_REMOVE_AT,
         FN_REMOVE_TAIL:   begin
            ok_in  = (c != '0) && (p < c);
            is_rem = 1'b1;
         end
         FN_REMOVE_KEY:    begin
            ok_in  = pre[CAPACITY-1];
            is_rem = 1'b1;
         end
         FN_CLEAR:         ok_in = 1'b1;
         default:          ok_in = 1'b0;
      endcase

      for (int k = 0; k < CAPACITY; k++) begin
         kk = CMP_W'(k);
         ctl_in[k] = '0;
         sel_in[k] = 1'b0;
         if (ok_in) begin
            case (func_ff)
               FN_READ_AT:       sel_in[k] = kk == p;
               FN_INSERT_AT,
               FN_INSERT_TAIL:   begin
                  ctl_in[k].put = kk == p;
                  ctl_in[k].up  = (kk > p) && (kk <= c);
               end
               FN_INSERT_SORTED: begin
                  ctl_in[k].put = (kk <= c) && !suf[k] && ((k == 0) || suf_lo[k]);
                  ctl_in[k].up  = (k != 0) && (kk <= c) && !suf_lo[k];
               end
               FN_REMOVE_AT,
               FN_REMOVE_TAIL:   begin
                  sel_in[k]      = kk == p;
                  ctl_in[k].down = (kk >= p) && (kk + CMP_W'(1) < c);
               end
               FN_REMOVE_KEY:    begin
                  sel_in[k]      = hit[k] && !pre_lo[k];
                  ctl_in[k].down = pre[k] && (kk + CMP_W'(1) < c);
               end
               default:          ctl_in[k] = '0;
            endcase
         end
      end

      count_nx_in = count_ff;
      if (ok_in) begin
         if (func_ff == FN_CLEAR) begin
            count_nx_in = '0;
         end else if (is_ins) begin
            count_nx_in = count_ff + CNT_W'(1);
         end else if (is_rem) begin
            count_nx_in = count_ff - CNT_W'(1);
         end
      end
   end

   // ---- sequencer ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         sel_ff       <= '0;
         for (int k = 0; k < CAPACITY; k++) begin
            ctl_ff[k] <= '0;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         sel_ff       <= '0;
         for (int k = 0; k < CAPACITY; k++) begin
            ctl_ff[k] <= '0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  func_ff  <= func_type'(req_func);
                  pos_ff   <= req_position;
                  key_ff   <= to_word(req_value_in);
                  state_ff <= ST_CMP;
               end
            end
            ST_CMP: begin
               state_ff <= ST_MASK;
            end
            ST_MASK: begin
               ok_ff       <= ok_in;
               count_nx_ff <= count_nx_in;
               sel_ff      <= sel_in;
               for (int k = 0; k < CAPACITY; k++) begin
                  ctl_ff[k] <= ctl_in[k];
               end
               state_ff <= ST_APPLY;
            end
            ST_APPLY: begin
               count_ff <= count_nx_ff;
               state_ff <= ST_DRAIN;
            end
            ST_DRAIN: begin
               rsp_valid_ff <= 1'b1;
               rsp_ok_ff    <= ok_ff;
               rsp_count_ff <= count_ff;
               rsp_free_ff  <= CNT_W'(CAPACITY) - count_ff;
               rsp_empty_ff <= count_ff == '0;
               rsp_full_ff  <= count_ff == CNT_W'(CAPACITY);
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy           = state_ff != ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_value_out  = pick_value;
   assign rsp_count      = rsp_count_ff;
   assign rsp_free_slots = rsp_free_ff;
   assign rsp_is_empty   = rsp_empty_ff;
   assign rsp_is_full    = rsp_full_ff;

   // ---- checks ----
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_value_out == '0))
      else $error("failed operation returned a value");

   a_count_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count + rsp_free_slots == CNT_W'(CAPACITY)))
      else $error("count and free slots disagree");

   a_one_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two responses in a row");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for array_list_engine. The bench mirrors the list and
// its count in a scoreboard object. Each accepted request word produces one
// expected response, and responses are matched in order, field by field.
// Traffic runs in three steps: a short directed list of edge cases, a fill
// to capacity and a drain to empty, then random grow, shrink and mixed
// segments. Random idle gaps sit between requests.
// ----------------------------------------------------------------------------
module tb;
   import alst_pkg::*;

   typedef struct {
      logic            ok;
      logic [IN_W-1:0] value;
      logic [CNT_W-1:0] count;
      logic [CNT_W-1:0] free_slots;
      logic            is_empty;
      logic            is_full;
   } reply_type;

   typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIXED} mode_type;

   class list_scoreboard;
      word_type  cells[CAPACITY];
      int        fill = 0;
      reply_type replies[$];
      int        errors = 0;

      function int pending();
         return replies.size();
      endfunction

      function logic [IN_W-1:0] stored_value(int idx);
         return IN_W'($signed(cells[idx]));
      endfunction

      // pull one entry out and close the gap
      function word_type take(int p);
         word_type w;
         w = cells[p];
         for (int i = p + 1; i < fill; i++) cells[i-1] = cells[i];
         fill--;
         return w;
      endfunction

      function void note_request(func_type fn, logic [POS_W-1:0] pos,
                                 logic [IN_W-1:0] vin);
         reply_type r;
         word_type  w;
         int        p;
         int        i;
         w = DATA_WIDTH'($signed(vin));
         p = int'(pos);
         r.ok = 1'b0;
         r.value = '0;
         case (fn)
            FN_READ_AT: begin
               if (p < fill) begin
                  r.value = stored_value(p);
                  r.ok = 1'b1;
               end
            end
            FN_INSERT_AT, FN_INSERT_TAIL: begin
               if (fn == FN_INSERT_TAIL) p = fill;
               if (fill < CAPACITY && p <= fill) begin
                  for (i = fill; i > p; i--) cells[i] = cells[i-1];
                  cells[p] = w;
                  fill++;
                  r.ok = 1'b1;
               end
            end
            FN_INSERT_SORTED: begin
               if (fill < CAPACITY) begin
                  i = fill;
                  while (i > 0 && $signed(w) < $signed(cells[i-1])) begin
                     cells[i] = cells[i-1];
                     i--;
                  end
                  cells[i] = w;
                  fill++;
                  r.ok = 1'b1;
               end
            end
            FN_REMOVE_AT, FN_REMOVE_TAIL: begin
               if (fn == FN_REMOVE_TAIL) p = fill - 1;
               if (fill > 0 && p >= 0 && p < fill) begin
                  r.value = IN_W'($signed(take(p)));
                  r.ok = 1'b1;
               end
            end
            FN_REMOVE_KEY: begin
               // lowest matching position wins
               for (i = 0; i < fill && !r.ok; i++) begin
                  if (cells[i] == w) begin
                     r.value = IN_W'($signed(take(i)));
                     r.ok = 1'b1;
                  end
               end
            end
            FN_CLEAR: begin
               fill = 0;
               r.ok = 1'b1;
            end
         endcase
         r.count = CNT_W'(fill);
         r.free_slots = CNT_W'(CAPACITY - fill);
         r.is_empty = (fill == 0);
         r.is_full = (fill == CAPACITY);
         replies.push_back(r);
      endfunction

      function void compare_field(string name, logic [IN_W-1:0] exp_v,
                                  logic [IN_W-1:0] act_v);
         if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_response(logic ok, logic [IN_W-1:0] value,
                                   logic [CNT_W-1:0] count,
                                   logic [CNT_W-1:0] free_slots,
                                   logic is_empty, logic is_full);
         reply_type e;
         if (replies.size() == 0) begin
            $display("%0t: response word with nothing expected, expected none, actual ok=%0b value=%0h",
                     $time, ok, value);
            errors++;
            return;
         end
         e = replies.pop_front();
         compare_field("ok", IN_W'(e.ok), IN_W'(ok));
         compare_field("value_out", e.value, value);
         compare_field("count", IN_W'(e.count), IN_W'(count));
         compare_field("free_slots", IN_W'(e.free_slots), IN_W'(free_slots));
         compare_field("is_empty", IN_W'(e.is_empty), IN_W'(is_empty));
         compare_field("is_full", IN_W'(e.is_full), IN_W'(is_full));
      endfunction
   endclass

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [2:0]             req_func = '0;
   logic [POS_W-1:0]       req_position = '0;
   logic signed [IN_W-1:0] req_value_in = '0;
   logic                   rsp_valid;
   logic                   rsp_ok;
   logic signed [IN_W-1:0] rsp_value_out;
   logic [CNT_W-1:0]       rsp_count;
   logic [CNT_W-1:0]       rsp_free_slots;
   logic                   rsp_is_empty;
   logic                   rsp_is_full;

   list_scoreboard sb = new();
   int  words_sent = 0;
   bit  steady = 1'b0;

   array_list_engine dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_position   (req_position),
      .req_value_in   (req_value_in),
      .rsp_valid      (rsp_valid),
      .rsp_ok         (rsp_ok),
      .rsp_value_out  (rsp_value_out),
      .rsp_count      (rsp_count),
      .rsp_free_slots (rsp_free_slots),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // response first: the word leaving is always older than one arriving
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1)
            sb.check_response(rsp_ok, rsp_value_out, rsp_count, rsp_free_slots,
                              rsp_is_empty, rsp_is_full);
         if (start && !busy)
            sb.note_request(func_type'(req_func), req_position, req_value_in);
      end
   end

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [IN_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return IN_W'(int'($urandom_range(0, 16)) - 8);
      if (r < 45) begin
         case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0001;
            default: return 32'h0;
         endcase
      end
      return $urandom();
   endfunction

   // hold the word until taken, then idle for a random gap
   task automatic send_word(func_type fn, int pos, logic [IN_W-1:0] v);
      int gap;
      req_func <= fn;
      req_position <= POS_W'(pos);
      req_value_in <= v;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      words_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic random_word(mode_type mode);
      int r;
      int ins_pct;
      int pos;
      int fill;
      func_type fn;
      logic [IN_W-1:0] v;
      fill = sb.fill;
      ins_pct = (mode == MODE_GROW) ? 70 : (mode == MODE_SHRINK) ? 15 : 40;
      r = $urandom_range(0, 99);
      if (r < ins_pct) begin
         case ($urandom_range(0, 2))
            0: fn = FN_INSERT_AT;
            1: fn = FN_INSERT_SORTED;
            default: fn = FN_INSERT_TAIL;
         endcase
      end else if (r < ins_pct + 15) begin
         fn = FN_READ_AT;
      end else if (r == 99 && mode == MODE_MIXED) begin
         fn = FN_CLEAR;
      end else begin
         case ($urandom_range(0, 2))
            0: fn = FN_REMOVE_AT;
            1: fn = FN_REMOVE_KEY;
            default: fn = FN_REMOVE_TAIL;
         endcase
      end
      r = $urandom_range(0, 9);
      if (r < 7) pos = $urandom_range(0, fill);
      else if (r < 9) pos = fill + int'($urandom_range(0, 2)) - 1;
      else pos = $urandom_range(0, 255);
      if (pos < 0) pos = 0;
      if (pos > 255) pos = 255;
      // keys mostly taken from the live list so removals hit
      if (fn == FN_REMOVE_KEY && fill > 0 && $urandom_range(0, 9) < 6)
         v = sb.stored_value(int'($urandom_range(0, fill - 1)));
      else
         v = pick_value();
      send_word(fn, pos, v);
   endtask

   initial begin
      int seg_len;
      mode_type mode;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list rejects, then directed inserts, reads and removals
      send_word(FN_READ_AT, 0, 32'h0);
      send_word(FN_REMOVE_AT, 0, 32'h0);
      send_word(FN_REMOVE_TAIL, 0, 32'h0);
      send_word(FN_REMOVE_KEY, 0, 32'h5);
      send_word(FN_CLEAR, 0, 32'h0);
      send_word(FN_INSERT_TAIL, 0, 32'h7fff_ffff);
      send_word(FN_INSERT_TAIL, 0, 32'h8000_0000);
      send_word(FN_INSERT_AT, 0, 32'hffff_ffff);
      send_word(FN_INSERT_AT, 3, 32'h0);         // position equal to count
      send_word(FN_INSERT_AT, 5, 32'h1);         // position past count
      send_word(FN_INSERT_SORTED, 0, 32'h7);
      send_word(FN_INSERT_SORTED, 0, 32'h7);     // duplicate key
      send_word(FN_INSERT_SORTED, 0, 32'hffff_fffb);
      send_word(FN_READ_AT, 255, 32'h0);
      send_word(FN_READ_AT, 0, 32'h0);
      send_word(FN_REMOVE_KEY, 0, 32'h7);
      send_word(FN_REMOVE_KEY, 0, 32'd12345);    // key not present
      send_word(FN_REMOVE_AT, 1, 32'h0);
      send_word(FN_REMOVE_TAIL, 0, 32'h0);
      send_word(FN_REMOVE_AT, 200, 32'h0);
      send_word(FN_CLEAR, 0, 32'h0);
      send_word(FN_INSERT_SORTED, 0, 32'h3);
      send_word(FN_READ_AT, 0, 32'h0);

      // fill to capacity, then hit the full list
      while (sb.fill < CAPACITY) random_word(MODE_GROW);
      send_word(FN_INSERT_TAIL, 0, pick_value());
      send_word(FN_INSERT_SORTED, 0, pick_value());
      send_word(FN_INSERT_AT, 255, pick_value());
      send_word(FN_READ_AT, 255, 32'h0);

      // hold off until every response is back; one edge first so the
      // last accepted word is already on the scoreboard
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      @(posedge clock);

      while (sb.fill > 0) random_word(MODE_SHRINK);
      send_word(FN_REMOVE_TAIL, 0, 32'h0);
      send_word(FN_REMOVE_AT, 0, 32'h0);

      while (words_sent < 1400) begin
         mode = mode_type'($urandom_range(0, 2));
         steady = ($urandom_range(0, 3) == 0);
         seg_len = $urandom_range(40, 200);
         repeat (seg_len) random_word(mode);
      end
      steady = 1'b0;
      start <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== array_list_engine.f =====
hdl/alst_pkg.sv
hdl/alst_cell.sv
hdl/alst_pick.sv
hdl/array_list_engine.sv
sim/tb.sv
